FILE: hw/rtl/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg: shared types and constants of the cascaded interrupt controller
// Item layouts, command codes, control word bit positions and the rotating
// priority search used by the datapath.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Command codes carried by an input item
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_RAISE = 3'd2;
  localparam logic [2:0] CMD_LOWER = 3'd3;
  localparam logic [2:0] CMD_POLL  = 3'd4;

  // Control word bit positions
  localparam int unsigned OCW2_EOI  = 5;
  localparam int unsigned OCW2_SL   = 6;
  localparam int unsigned OCW2_ROT  = 7;
  localparam int unsigned OCW3_RIS  = 0;
  localparam int unsigned OCW3_RR   = 1;
  localparam int unsigned OCW3_SMM  = 5;
  localparam int unsigned OCW3_ESMM = 6;

  // Word kind in bits 4:3 of a command port write
  localparam logic [1:0] KIND_OCW2 = 2'b00;
  localparam logic [1:0] KIND_OCW3 = 2'b01;

  // Reset values
  localparam logic [7:0] MASK_RST_MASTER = 8'h7d;
  localparam logic [7:0] MASK_RST_SLAVE  = 8'h71;
  localparam logic [63:0] ICW_RST = 64'h09_07_10_11_1d_80_08_11; // word 0 lowest

  typedef struct packed {
    logic [2:0] command;
    logic       chip_select;
    logic       register_select;
    logic [7:0] write_data;
    logic [3:0] irq_line;
    logic       cpu_accepts;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_valid;
    logic [7:0] int_vector;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cic_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } cic_status_t;

  // First set bit of v from start upward, wrapping round
  function automatic logic [2:0] rot_find(input logic [7:0] v, input logic [2:0] start);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic [2:0]  off;
    dbl = {v, v};
    rot = dbl[start +: 8];
    off = '0;
    for (int i = 7; i >= 0; i--) begin
      if (rot[i]) off = 3'(i);
    end
    return start + off;
  endfunction

endpackage

FILE: hw/rtl/cic_ctrl.sv
// ----------------------------------------------------------------------------
// cic_ctrl: item sequencer
// Takes one item, holds the input side off while the datapath executes it,
// and waits for the output register to free up before executing.
// ----------------------------------------------------------------------------
module cic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cic_pkg::cic_status_t status_i,
  output cic_pkg::cic_cmd_t    cmd_o
);
  import cic_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   stall_q;

  // Drive datapath commands
  assign cmd_o.capture = in_valid_i && !stall_q;
  assign cmd_o.execute = (state_q == ST_EXEC) && status_i.out_free;
  assign in_stall_o    = stall_q;

  // Advance state, hold off the input side while an item is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_EXEC;
            stall_q <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (cmd_o.execute) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC) && stall_q)
    else $error("captured item did not enter execution");

  a_exec_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> (state_q == ST_IDLE) && !stall_q)
    else $error("executed item did not release the input side");

  a_exec_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> stall_q)
    else $error("input side open while an item executes");

endmodule

FILE: hw/rtl/cic_datapath.sv
// ----------------------------------------------------------------------------
// cic_datapath: register file and priority logic of the controller pair
// Holds request, mask, in-service, init word and mode state for master and
// slave, executes one captured item and loads the result register.
// ----------------------------------------------------------------------------
module cic_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cic_pkg::in_item_t     in_item_i,
  input  cic_pkg::cic_cmd_t     cmd_i,
  output cic_pkg::cic_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cic_pkg::out_item_t    out_item_o
);
  import cic_pkg::*;

  in_item_t  item_q;
  out_item_t out_item_q, out_item_d;
  logic      out_valid_q;

  logic [7:0] req_q   [2];
  logic [7:0] req_d   [2];
  logic [7:0] mask_q  [2];
  logic [7:0] mask_d  [2];
  logic [7:0] isr_q   [2];
  logic [7:0] isr_d   [2];
  logic [7:0] ocw3_q  [2];
  logic [7:0] ocw3_d  [2];
  logic [2:0] prio_q  [2];
  logic [2:0] prio_d  [2];
  logic [1:0] step_q  [2];
  logic [1:0] step_d  [2];
  logic [7:0] icw_q   [8];
  logic [7:0] icw_d   [8];

  // Poll search terms
  logic [7:0] sir, cas, mir_raw, mir, m_bit, sir_f, s_bit;
  logic [2:0] m_num, s_num;
  logic       via_slave, poll_hit;

  // Write decode terms
  logic       c;
  logic [7:0] d;
  logic [2:0] eoi_level;
  logic [1:0] step_nx;
  logic [2:0] line_no;

  assign c       = item_q.chip_select;
  assign d       = item_q.write_data;
  assign line_no = item_q.irq_line[2:0];

  // Master search, then descend into the slave on a cascade input
  assign sir       = req_q[1] & ~mask_q[1];
  assign cas       = 8'b1 << icw_q[6][2:0];
  assign mir_raw   = (req_q[0] | ((sir != 8'h00) ? cas : 8'h00)) & ~mask_q[0];
  assign mir       = ocw3_q[0][OCW3_SMM] ? mir_raw : (mir_raw | isr_q[0]);
  assign m_num     = rot_find(mir, prio_q[0]);
  assign m_bit     = 8'b1 << m_num;
  assign via_slave = (icw_q[2] & m_bit) != 8'h00;
  assign sir_f     = ocw3_q[1][OCW3_SMM] ? sir : (sir | isr_q[1]);
  assign s_num     = rot_find(sir_f, prio_q[1]);
  assign s_bit     = 8'b1 << s_num;
  assign poll_hit  = item_q.cpu_accepts && (mir_raw != 8'h00) &&
                     (via_slave ? ((sir != 8'h00) && ((isr_q[1] & s_bit) == 8'h00))
                                : ((isr_q[0] & m_bit) == 8'h00));

  // End of interrupt level (specific or non-specific), next init step
  assign eoi_level = d[OCW2_SL] ? d[2:0] : rot_find(isr_q[c], prio_q[c]);
  assign step_nx   = step_q[c] + 2'd1;

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

  // Execute the captured item
  always_comb begin
    req_d      = req_q;
    mask_d     = mask_q;
    isr_d      = isr_q;
    ocw3_d     = ocw3_q;
    prio_d     = prio_q;
    step_d     = step_q;
    icw_d      = icw_q;
    out_item_d = '0;
    case (item_q.command)
      CMD_WRITE: begin
        if (item_q.register_select) begin
          if (step_q[c] == 2'd0) begin
            mask_d[c] = d;
          end else begin
            icw_d[{c, step_q[c]}] = d;
            if ({1'b0, step_nx} >= (3'd3 + {2'b00, icw_q[{c, 2'b00}][0]})) begin
              step_d[c] = 2'd0;
            end else begin
              step_d[c] = step_nx;
            end
          end
        end else begin
          step_d[c] = 2'd0;
          case (d[4:3])
            KIND_OCW2: begin
              if (d[OCW2_SL] || (isr_q[c] != 8'h00)) begin
                if (d[OCW2_ROT]) prio_d[c] = eoi_level + 3'd1;
                if (d[OCW2_EOI]) isr_d[c] = isr_q[c] & ~(8'b1 << eoi_level);
              end
            end
            KIND_OCW3: begin
              ocw3_d[c] = d;
              if (!d[OCW3_RR])   ocw3_d[c][OCW3_RIS] = ocw3_q[c][OCW3_RIS];
              if (!d[OCW3_ESMM]) ocw3_d[c][OCW3_SMM] = ocw3_q[c][OCW3_SMM];
            end
            default: begin
              icw_d[{c, 2'b00}] = d;
              mask_d[c] = '0;
              req_d[c]  = '0;
              ocw3_d[c] = '0;
              prio_d[c] = '0;
              step_d[c] = 2'd1;
            end
          endcase
        end
      end
      CMD_READ: begin
        if (item_q.register_select) begin
          out_item_d.read_data = mask_q[c];
        end else begin
          out_item_d.read_data = ocw3_q[c][OCW3_RIS] ? isr_q[c] : req_q[c];
        end
      end
      CMD_RAISE: begin
        req_d[item_q.irq_line[3]] = req_q[item_q.irq_line[3]] | (8'b1 << line_no);
      end
      CMD_LOWER: begin
        req_d[item_q.irq_line[3]] = req_q[item_q.irq_line[3]] & ~(8'b1 << line_no);
      end
      CMD_POLL: begin
        if (poll_hit) begin
          out_item_d.int_valid = 1'b1;
          if (via_slave) begin
            isr_d[0] = isr_q[0] | cas;
            req_d[0] = req_q[0] & ~cas;
            isr_d[1] = isr_q[1] | s_bit;
            req_d[1] = req_q[1] & ~s_bit;
            out_item_d.int_vector = {icw_q[5][7:3], s_num};
          end else begin
            isr_d[0] = isr_q[0] | m_bit;
            req_d[0] = req_q[0] & ~m_bit;
            out_item_d.int_vector = {icw_q[1][7:3], m_num};
          end
        end
      end
      default: begin
        out_item_d = '0;
      end
    endcase
  end

  // Hold the captured item and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.execute) out_item_q <= out_item_d;
  end

  // Update controller state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q[0]   <= MASK_RST_MASTER;
      mask_q[1]   <= MASK_RST_SLAVE;
      for (int i = 0; i < 2; i++) begin
        req_q[i]  <= '0;
        isr_q[i]  <= '0;
        ocw3_q[i] <= '0;
        prio_q[i] <= '0;
        step_q[i] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        icw_q[i] <= ICW_RST[8*i +: 8];
      end
    end else begin
      if (cmd_i.execute) begin
        out_valid_q <= 1'b1;
        req_q  <= req_d;
        mask_q <= mask_d;
        isr_q  <= isr_d;
        ocw3_q <= ocw3_d;
        prio_q <= prio_d;
        step_q <= step_d;
        icw_q  <= icw_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.execute))
    else $error("result appeared without an executed item");

  a_exec_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

endmodule

FILE: hw/rtl/cascaded_interrupt_controller.sv
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller: master and slave interrupt controller pair
// Register access, request line events and acknowledge polls, one item
// producing one result item.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is captured, then executed when the output
//   register is free; a held result delays execution until it is taken.
// The input side stalls while an item executes, so a new item is accepted
//   only after the last one has executed.
// A finished result waits in the output register while the next item enters.
// Reset: asynchronous, masks 0x7d/0x71, init words 11 08 80 1d / 11 10 07 09,
//   all other state cleared; items accepted from the first cycle after reset.
module cascaded_interrupt_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cic_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cic_pkg::out_item_t out_item_o
);
  import cic_pkg::*;

  cic_cmd_t    cmd;
  cic_status_t status;

  // Sequence items
  cic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Execute items against the register file
  cic_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
